@@ src/set_assoc_branch_target_buffer_macros.svh @@
// Assertion macros for the branch target buffer checker.
`ifndef SET_ASSOC_BRANCH_TARGET_BUFFER_MACROS_SVH
`define SET_ASSOC_BRANCH_TARGET_BUFFER_MACROS_SVH

// Implication within the same cycle.
`define SABTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define SABTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication with a delayed consequent.
`define SABTB_ASSERT_TWO(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

@@ src/sabtb_pkg.sv @@
// Shared types and constants for the set-associative branch target buffer.
`timescale 1ns / 1ps

package sabtb_pkg;

  localparam int SET_IDX_W_DEF = 6;
  localparam int WAYS_DEF      = 4;

  localparam int ADDR_W = 32;
  localparam int KIND_W = 2;

  localparam int S_DATA_W = 72;  // pc + target + kind, byte padded
  localparam int M_DATA_W = 40;  // target + kind, byte padded

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] target;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] target;
    logic [KIND_W-1:0] kind;
  } result_t;

endpackage

@@ src/sabtb_set_update.sv @@
// Way match, victim choice and row rewrite for one set of the buffer.
`timescale 1ns / 1ps

module sabtb_set_update #(
  parameter int WAYS  = sabtb_pkg::WAYS_DEF,
  parameter int PTR_W = 2
) (
  input  sabtb_pkg::entry_t [WAYS-1:0]       ways_in,
  input  logic [PTR_W-1:0]                   ptr_in,
  input  logic                               func,
  input  logic [sabtb_pkg::ADDR_W-1:0]       pc,
  input  logic [sabtb_pkg::ADDR_W-1:0]       target,
  input  logic [sabtb_pkg::KIND_W-1:0]       kind,
  output sabtb_pkg::entry_t [WAYS-1:0]       ways_out,
  output logic [PTR_W-1:0]                   ptr_out,
  output sabtb_pkg::result_t                 result
);

  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   free;
  logic [PTR_W-1:0]  match_idx;
  logic [PTR_W-1:0]  free_idx;
  logic [PTR_W-1:0]  victim;
  logic              hit;
  logic              any_free;
  logic              is_update;
  sabtb_pkg::entry_t sel;

  assign is_update = (func == sabtb_pkg::FUNC_UPDATE);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = ways_in[w].valid && (ways_in[w].tag == pc);
      free[w]  = !ways_in[w].valid;
    end
  end

  assign hit      = |match;
  assign any_free = |free;

  // lowest-numbered way wins: scan downwards so the last assignment sticks
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        match_idx = PTR_W'(w);
      end
      if (free[w]) begin
        free_idx = PTR_W'(w);
      end
    end
  end

  assign victim = hit ? match_idx : (any_free ? free_idx : ptr_in);

  always_comb begin
    ptr_out = ptr_in;
    if (is_update && !hit && !any_free) begin
      ptr_out = (ptr_in == PTR_W'(WAYS - 1)) ? '0 : PTR_W'(ptr_in + 1'b1);
    end
  end

  always_comb begin
    ways_out = ways_in;
    if (is_update) begin
      for (int w = 0; w < WAYS; w++) begin
        if (PTR_W'(w) == victim) begin
          ways_out[w].valid  = 1'b1;
          ways_out[w].tag    = pc;
          ways_out[w].target = target;
          ways_out[w].kind   = kind;
        end
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (PTR_W'(w) == match_idx) begin
        sel = ways_in[w];
      end
    end
  end

  always_comb begin
    result.hit    = hit;
    result.target = '0;
    result.kind   = '0;
    if (!is_update && hit) begin
      result.target = sel.target;
      result.kind   = sel.kind;
    end
  end

endmodule

@@ src/set_assoc_branch_target_buffer.sv @@
// Timing: a transaction accepted in the idle state is looked up in the lookup state, and its
// result is registered from there, unless an earlier result still waits in the output register.
// Flow: a new transaction is taken only in the idle state, once the read-modify-write of a set
// row through the row memory (registered read, then write-back from the lookup state) is done.
// Reset: a clearing pass writes every set row to zero, with s_tready low while it runs;
// valid bits and round-robin pointers live in the rows and are cleared by that pass.
`timescale 1ns / 1ps

module set_assoc_branch_target_buffer #(
  parameter int SET_IDX_W = sabtb_pkg::SET_IDX_W_DEF,
  parameter int WAYS      = sabtb_pkg::WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sabtb_pkg::S_DATA_W-1:0]   s_tdata,   // pc, branch_target, branch_kind, pad
  input  logic                             s_tuser,   // func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sabtb_pkg::M_DATA_W-1:0]   m_tdata,   // found_target, found_kind, pad
  output logic                             m_tuser    // hit
);

  localparam int SETS  = 1 << SET_IDX_W;
  localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW    = $bits(sabtb_pkg::entry_t);
  localparam int ROW_W = WAYS * EW + PTR_W;
  localparam int AW    = sabtb_pkg::ADDR_W;
  localparam int KW    = sabtb_pkg::KIND_W;
  localparam int PAD_W = sabtb_pkg::M_DATA_W - AW - KW;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [ROW_W-1:0]      mem [SETS];
  logic [ROW_W-1:0]      rd_row;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [SET_IDX_W-1:0]  clr_idx;

  logic                  func;
  logic [AW-1:0]         pc;
  logic [AW-1:0]         branch_target;
  logic [KW-1:0]         branch_kind;

  logic                  accept;
  logic                  out_free;
  logic                  mem_we;
  logic [SET_IDX_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;

  sabtb_pkg::entry_t [WAYS-1:0] ways_new;
  logic [PTR_W-1:0]             ptr_new;
  sabtb_pkg::result_t           result;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  sabtb_set_update #(
    .WAYS  (WAYS),
    .PTR_W (PTR_W)
  ) u_set_update (
    .ways_in  (rd_row[WAYS*EW-1:0]),
    .ptr_in   (rd_row[ROW_W-1 -: PTR_W]),
    .func     (func),
    .pc       (pc),
    .target   (branch_target),
    .kind     (branch_kind),
    .ways_out (ways_new),
    .ptr_out  (ptr_new),
    .result   (result)
  );

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = pc[SET_IDX_W+1:2];
    mem_wdata  = {ptr_new, ways_new};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        if (clr_idx == SET_IDX_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          mem_we     = (func == sabtb_pkg::FUNC_UPDATE);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // set row store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_row <= mem[s_tdata[SET_IDX_W+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func          <= s_tuser;
      pc            <= s_tdata[AW-1:0];
      branch_target <= s_tdata[2*AW-1:AW];
      branch_kind   <= s_tdata[2*AW+KW-1:2*AW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_LOOKUP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP && out_free) begin
      m_tdata <= {{PAD_W{1'b0}}, result.kind, result.target};
      m_tuser <= result.hit;
    end
  end

endmodule

@@ src/sabtb_check.sv @@
// Port-level checker for the branch target buffer, bound to the top level.
`timescale 1ns / 1ps
`include "set_assoc_branch_target_buffer_macros.svh"

module sabtb_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [sabtb_pkg::M_DATA_W-1:0] m_tdata,
  input logic                           m_tuser
);

  `SABTB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `SABTB_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `SABTB_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "second transaction taken while one is in flight")
  `SABTB_ASSERT_TWO(a_result_due, clk, rst, s_tvalid && s_tready, m_tvalid, "no result two cycles after a transaction")
  `SABTB_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0, "miss carries non-zero data")

endmodule

bind set_assoc_branch_target_buffer sabtb_check u_sabtb_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
